FILE: design/wss_pkg.sv
// Shared types and constants of the wildcard signature scanner.
// Used by wss_cfg, wss_window and the top level wildcard_signature_scan.
package wss_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CareW    = 16;
  localparam int unsigned PatBytes = 16;
  localparam int unsigned PatIdxW  = 4;
  localparam int unsigned LenCfgW  = 5;
  localparam int unsigned SelW     = 32;
  localparam int unsigned OutOffW  = 32;
  localparam int unsigned AddrW    = 64;

  localparam logic [CareW-1:0]   CareMaskRst      = 16'hFFFF;
  localparam logic [LenCfgW-1:0] PatternLengthRst = 5'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_LOW    = CfgIdxW'(0),
    CFG_PATTERN_HIGH   = CfgIdxW'(1),
    CFG_CARE_MASK      = CfgIdxW'(2),
    CFG_PATTERN_LENGTH = CfgIdxW'(3),
    CFG_SELECT_INDEX   = CfgIdxW'(4),
    CFG_BASE_ADDRESS   = CfgIdxW'(5)
  } cfg_reg_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             region_end;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [OutOffW-1:0] match_offset;
    logic [AddrW-1:0]   match_address;
  } out_item_t;

  // History control from the scan controller to the window unit.
  typedef struct packed {
    logic shift;
    logic clear;
  } hist_ctrl_t;

endpackage

FILE: design/wss_cfg.sv
// Configuration registers of the scanner and the alignment of pattern and care
// bits to window positions. Depends on wss_pkg.
module wss_cfg #(
  parameter int unsigned MaxPattern = 16,
  parameter int unsigned LenW       = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wss_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [wss_pkg::CfgDataW-1:0]        cfg_wdata_i,
  output logic [LenW-1:0]                     len_o,
  output logic [MaxPattern-1:0]               care_o,
  output logic [MaxPattern-1:0][wss_pkg::ByteW-1:0] pat_o,
  output logic [wss_pkg::SelW-1:0]            select_o,
  output logic [wss_pkg::AddrW-1:0]           base_o
);

  logic [63:0]                  pat_low_q;
  logic [63:0]                  pat_high_q;
  logic [wss_pkg::CareW-1:0]    care_q;
  logic [wss_pkg::LenCfgW-1:0]  plen_q;
  logic [wss_pkg::SelW-1:0]     sel_q;
  logic [wss_pkg::AddrW-1:0]    base_q;
  logic [wss_pkg::PatBytes-1:0][wss_pkg::ByteW-1:0] pat_all;
  logic [LenW-1:0]              plen_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      care_q     <= wss_pkg::CareMaskRst;
      plen_q     <= wss_pkg::PatternLengthRst;
      sel_q      <= '0;
      base_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (wss_pkg::cfg_reg_e'(cfg_index_i))
        wss_pkg::CFG_PATTERN_LOW:    pat_low_q  <= cfg_wdata_i;
        wss_pkg::CFG_PATTERN_HIGH:   pat_high_q <= cfg_wdata_i;
        wss_pkg::CFG_CARE_MASK:      care_q     <= cfg_wdata_i[wss_pkg::CareW-1:0];
        wss_pkg::CFG_PATTERN_LENGTH: plen_q     <= cfg_wdata_i[wss_pkg::LenCfgW-1:0];
        wss_pkg::CFG_SELECT_INDEX:   sel_q      <= cfg_wdata_i[wss_pkg::SelW-1:0];
        wss_pkg::CFG_BASE_ADDRESS:   base_q     <= cfg_wdata_i[wss_pkg::AddrW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length into 1..MaxPattern.
  assign plen_ext = LenW'(plen_q);

  always_comb begin
    if (plen_q == '0) begin
      len_o = LenW'(1);
    end else if (plen_ext > LenW'(MaxPattern)) begin
      len_o = LenW'(MaxPattern);
    end else begin
      len_o = plen_ext;
    end
  end

  assign pat_all  = {pat_high_q, pat_low_q};
  assign select_o = sel_q;
  assign base_o   = base_q;

  // Window position k lies k bytes back from the newest byte; it faces
  // pattern byte len-1-k. Bytes past the sixteenth are wildcards.
  for (genvar k = 0; k < MaxPattern; k++) begin : g_align
    logic [LenW-1:0] j;
    logic            in_use;
    assign in_use   = LenW'(k) < len_o;
    assign j        = len_o - LenW'(k) - LenW'(1);
    assign care_o[k] = in_use && (j < LenW'(wss_pkg::PatBytes)) &&
                       care_q[j[wss_pkg::PatIdxW-1:0]];
    assign pat_o[k]  = pat_all[j[wss_pkg::PatIdxW-1:0]];
  end

endmodule

FILE: design/wss_window.sv
// Byte history shift line and the parallel window compare of the scanner.
// Depends on wss_pkg.
module wss_window #(
  parameter int unsigned MaxPattern = 16,
  parameter int unsigned LenW       = 5
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  wss_pkg::hist_ctrl_t                       ctrl_i,
  input  logic [wss_pkg::ByteW-1:0]                 cur_byte_i,
  input  logic [LenW-1:0]                           len_i,
  input  logic [MaxPattern-1:0]                     care_i,
  input  logic [MaxPattern-1:0][wss_pkg::ByteW-1:0] pat_i,
  output logic                                      hit_o
);

  localparam int unsigned HistCap = MaxPattern - 1;
  localparam int unsigned HistD   = (MaxPattern > 1) ? MaxPattern - 1 : 1;

  logic [HistD-1:0][wss_pkg::ByteW-1:0]      hist_q;
  logic [LenW-1:0]                           fill_q;
  logic [MaxPattern-1:0][wss_pkg::ByteW-1:0] win;
  logic [MaxPattern-1:0]                     pos_ok;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      for (int i = HistD - 1; i > 0; i--) begin
        hist_q[i] <= hist_q[i-1];
      end
      hist_q[0] <= cur_byte_i;
    end
  end

  // Count valid history bytes; saturate at the history depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (ctrl_i.clear) begin
      fill_q <= '0;
    end else if (ctrl_i.shift && (fill_q < LenW'(HistCap))) begin
      fill_q <= fill_q + LenW'(1);
    end
  end

  assign win[0] = cur_byte_i;
  for (genvar k = 1; k < MaxPattern; k++) begin : g_win
    assign win[k] = hist_q[k-1];
  end

  for (genvar k = 0; k < MaxPattern; k++) begin : g_cmp
    assign pos_ok[k] = !care_i[k] || (win[k] == pat_i[k]);
  end

  assign hit_o = (&pos_ok) && (fill_q >= (len_i - LenW'(1)));

endmodule

FILE: design/wildcard_signature_scan.sv
// Wildcard byte-pattern scanner: top level with input stage, scan control and
// result register. Depends on wss_pkg, wss_cfg and wss_window.
//
// The scanner takes one byte of a memory region per transfer on the input
// channel, with region_end set on the final byte, and compares every complete
// window of pattern_length bytes against the configured pattern in a single
// pass; pattern positions whose care bit is clear match any byte. The first
// select_index matches are skipped and the next one is delivered once as a
// result transfer with found set, its region offset and base_address plus
// that offset; later bytes of the same region then produce nothing. If the
// region ends before that match, a single not-found result (all fields zero)
// follows the final byte. After the final byte the scan state returns to its
// reset values, while the configuration registers keep theirs. The input
// channel takes one byte per clock: each byte is registered, matched against
// the window by parallel byte compares, and its result moves to the output
// register once it is free. Only a stall on the output channel while a result
// is held there slows intake. The user must write configuration through
// cfg_we_i / cfg_index_i / cfg_wdata_i only while no byte is in flight, which
// the block does not enforce; indexes past base_address are ignored.
module wildcard_signature_scan #(
  parameter int unsigned MAX_PATTERN  = 16,
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [wss_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [wss_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // byte stream in
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  wss_pkg::in_item_t              in_data_i,
  // results out
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output wss_pkg::out_item_t             out_data_o
);

  localparam int unsigned LenNeedW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned LenW     = (LenNeedW > wss_pkg::LenCfgW) ? LenNeedW
                                                                    : wss_pkg::LenCfgW;

  // configuration view
  logic [LenW-1:0]                                   len;
  logic [MAX_PATTERN-1:0]                            care;
  logic [MAX_PATTERN-1:0][wss_pkg::ByteW-1:0]        pat;
  logic [wss_pkg::SelW-1:0]                          select_idx;
  logic [wss_pkg::AddrW-1:0]                         base_addr;

  // input stage
  logic                 s1_valid_q;
  wss_pkg::in_item_t    s1_data_q;
  logic                 s1_adv;
  logic                 out_free;
  logic                 in_accept;

  // scan state
  logic [OFFSET_WIDTH-1:0]   pos_q;
  logic [wss_pkg::SelW-1:0]  seen_q;
  logic                      given_q;

  // match and result
  wss_pkg::hist_ctrl_t       hist_ctrl;
  logic                      hit;
  logic                      hit_ok;
  logic                      take;
  logic                      skip;
  logic                      last;
  logic [OFFSET_WIDTH-1:0]   off;
  logic                      res_valid;
  wss_pkg::out_item_t        res;

  logic                      out_valid_q;
  wss_pkg::out_item_t        out_data_q;

  wss_cfg #(
    .MaxPattern (MAX_PATTERN),
    .LenW       (LenW)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .len_o       (len),
    .care_o      (care),
    .pat_o       (pat),
    .select_o    (select_idx),
    .base_o      (base_addr)
  );

  wss_window #(
    .MaxPattern (MAX_PATTERN),
    .LenW       (LenW)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (hist_ctrl),
    .cur_byte_i (s1_data_q.data_byte),
    .len_i      (len),
    .care_i     (care),
    .pat_i      (pat),
    .hit_o      (hit)
  );

  // Advance the input stage whenever the result register can take a value.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= in_data_i;
    end
  end

  // Skip matches until select_index of them are seen, then report once.
  assign last   = s1_data_q.region_end;
  assign hit_ok = !given_q && hit;
  assign skip   = hit_ok && (seen_q < select_idx);
  assign take   = hit_ok && !skip;

  // Offset of the window start; wraps with the byte counter.
  assign off = pos_q - OFFSET_WIDTH'(len - LenW'(1));

  assign res_valid = take || (last && !given_q);

  always_comb begin
    res.found         = take;
    res.match_offset  = '0;
    res.match_address = '0;
    if (take) begin
      res.match_offset  = wss_pkg::OutOffW'(off);
      res.match_address = base_addr + wss_pkg::AddrW'(off);
    end
  end

  assign hist_ctrl.shift = s1_adv && !last;
  assign hist_ctrl.clear = s1_adv && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      seen_q  <= '0;
      given_q <= 1'b0;
    end else if (s1_adv) begin
      if (last) begin
        pos_q   <= '0;
        seen_q  <= '0;
        given_q <= 1'b0;
      end else begin
        pos_q   <= pos_q + OFFSET_WIDTH'(1);
        if (skip) begin
          seen_q <= seen_q + wss_pkg::SelW'(1);
        end
        if (take) begin
          given_q <= 1'b1;
        end
      end
    end
  end

  // Result register: load on a new result, drop once transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The byte that closes a region leaves the scan state at its reset values.
  a_region_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && last |=> (pos_q == '0) && (seen_q == '0) && !given_q)
    else $error("scan state not cleared after region end");

  // Intake only stalls while a byte waits behind a held result.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a held result");

  // A reported match inside a region blocks any further report.
  a_report_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && take && !last |=> given_q)
    else $error("reported match not recorded");

endmodule
